FILE: hdl/pvs_pkg.sv
`default_nettype none

package pvs_pkg;

	// Polynomial size and fixed-point format
	localparam int NUM_COEFFS = 8;
	localparam int FRAC_BITS  = 16;
	localparam int NUM_REGS   = 8;
	localparam int REG_IDX_W  = 3;
	localparam int COEF_W     = 32;
	localparam int T_W        = 18;

	// Exact product of accumulator and t, plus one guard bit for rounding
	localparam int PROD_W = COEF_W + T_W;
	localparam int SUM_W  = PROD_W + 1;

	// One Horner step per coefficient above the constant term
	localparam int NUM_STEPS = NUM_COEFFS - 1;
	localparam int LATENCY   = 2 * NUM_STEPS + 1;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// Control that travels with each request through the pipeline
	typedef struct packed {
		logic                  vld;
		logic                  ovf;
		logic signed [T_W-1:0] t;
	} ctrl_t;

	// Saturated value and its saturation flag
	typedef struct packed {
		logic  ovf;
		coef_t val;
	} sat_t;

	localparam logic signed [SUM_W-1:0] SAT_HI  = SUM_W'(32'sh7fffffff);
	localparam logic signed [SUM_W-1:0] SAT_LO  = ~SAT_HI;
	localparam logic signed [SUM_W-1:0] RND_ADD = SUM_W'(1) <<< (FRAC_BITS - 1);

	// Clamp a wide value to 32 bits
	function automatic sat_t sat_wide(input logic signed [SUM_W-1:0] x);
		sat_t r;
		if (x > SAT_HI) begin
			r.ovf = 1'b1;
			r.val = coef_t'(SAT_HI);
		end else if (x < SAT_LO) begin
			r.ovf = 1'b1;
			r.val = coef_t'(SAT_LO);
		end else begin
			r.ovf = 1'b0;
			r.val = x[COEF_W-1:0];
		end
		return r;
	endfunction

	// Round half up, drop the fraction bits of t, clamp
	function automatic sat_t round_sat(input prod_t p);
		logic signed [SUM_W-1:0] sum;
		sum = SUM_W'(p) + RND_ADD;
		return sat_wide(sum >>> FRAC_BITS);
	endfunction

	// Saturating 32-bit add
	function automatic sat_t add_sat(input coef_t a, input coef_t b);
		return sat_wide(SUM_W'(a) + SUM_W'(b));
	endfunction

endpackage

`default_nettype wire

FILE: hdl/pvs_step.sv
`default_nettype none

module pvs_step (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pvs_pkg::ctrl_t   ctrl_in,
	input  wire pvs_pkg::prod_t   prod_val_in,
	input  wire pvs_pkg::prod_t   prod_slp_in,
	input  wire pvs_pkg::coef_t   coef_val,
	input  wire pvs_pkg::coef_t   coef_slp,
	output pvs_pkg::ctrl_t        ctrl_out,
	output pvs_pkg::prod_t        prod_val_out,
	output pvs_pkg::prod_t        prod_slp_out
);

	pvs_pkg::sat_t  rnd_val, rnd_slp, add_val, add_slp;
	logic           vld_s1, vld_s2;
	logic           ovf_s1, ovf_s2;
	logic signed [pvs_pkg::T_W-1:0] t_s1, t_s2;
	pvs_pkg::coef_t acc_val_s1, acc_slp_s1;
	pvs_pkg::prod_t prod_val_s2, prod_slp_s2;

	// Round the incoming product, then add this step's coefficient
	always_comb begin
		rnd_val = pvs_pkg::round_sat(prod_val_in);
		rnd_slp = pvs_pkg::round_sat(prod_slp_in);
		add_val = pvs_pkg::add_sat(rnd_val.val, coef_val);
		add_slp = pvs_pkg::add_sat(rnd_slp.val, coef_slp);
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ctrl_in.vld;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1: saturated accumulators
	always_ff @(posedge clk) begin
		ovf_s1     <= ctrl_in.ovf | rnd_val.ovf | rnd_slp.ovf | add_val.ovf | add_slp.ovf;
		t_s1       <= ctrl_in.t;
		acc_val_s1 <= add_val.val;
		acc_slp_s1 <= add_slp.val;
	end

	// Stage 2: multiply both accumulators by t
	always_ff @(posedge clk) begin
		ovf_s2      <= ovf_s1;
		t_s2        <= t_s1;
		prod_val_s2 <= pvs_pkg::PROD_W'(acc_val_s1) * pvs_pkg::PROD_W'(t_s1);
		prod_slp_s2 <= pvs_pkg::PROD_W'(acc_slp_s1) * pvs_pkg::PROD_W'(t_s1);
	end

	assign ctrl_out     = {vld_s2, ovf_s2, t_s2};
	assign prod_val_out = prod_val_s2;
	assign prod_slp_out = prod_slp_s2;

endmodule

`default_nettype wire

FILE: hdl/polynomial_value_and_slope_unit.sv
`default_nettype none

// Polynomial value and slope unit.
// Evaluates p(t) and p'(t) by Horner's rule in Q16.16 with saturation.
// Coefficients are written through cfg_we / cfg_idx / cfg_data, one per
// cycle, and take effect for requests issued after the write; write them
// only while no request is in flight. The slope coefficients are derived
// from them in a register in the cycle after each write.
// A request is taken on each rising edge with start high and busy low;
// busy stays low, so one request per cycle is sustained.
// Each Horner step takes two stages (round and add, then multiply by t),
// and a last stage adds the constant term and registers the result.
// done is high for exactly one cycle with poly_value, poly_slope and
// overflow; the receiver cannot hold it.
// Reset clears the coefficients to zero and drops all requests in flight.
module polynomial_value_and_slope_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic signed [pvs_pkg::T_W-1:0]         param_t,
	output logic                                        done,
	output logic signed [pvs_pkg::COEF_W-1:0]           poly_value,
	output logic signed [pvs_pkg::COEF_W-1:0]           poly_slope,
	output logic                                        overflow,
	input  wire logic                                   cfg_we,
	input  wire logic [pvs_pkg::REG_IDX_W-1:0]          cfg_idx,
	input  wire logic [pvs_pkg::COEF_W-1:0]             cfg_data
);

	pvs_pkg::coef_t coef_q  [pvs_pkg::NUM_REGS];
	pvs_pkg::coef_t dcoef_q [pvs_pkg::NUM_COEFFS-1];
	logic           dovf_q;
	pvs_pkg::sat_t  dscale_w [pvs_pkg::NUM_COEFFS-1];
	logic           dovf_w;

	pvs_pkg::ctrl_t ctrl_w     [pvs_pkg::NUM_STEPS+1];
	pvs_pkg::prod_t prod_val_w [pvs_pkg::NUM_STEPS+1];
	pvs_pkg::prod_t prod_slp_w [pvs_pkg::NUM_STEPS+1];
	pvs_pkg::coef_t coef_slp_w [pvs_pkg::NUM_STEPS];

	pvs_pkg::sat_t  rnd_val, rnd_slp, fin_val, fin_slp;
	logic           done_q;
	logic           ovf_q;
	pvs_pkg::coef_t val_q, slp_q;
	logic           accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Hold the coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pvs_pkg::NUM_REGS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			coef_q[cfg_idx] <= cfg_data;
		end
	end

	// Scale coefficient k+1 by k+1 for the derivative list
	for (genvar k = 0; k < pvs_pkg::NUM_COEFFS - 1; k++) begin : g_dscale
		assign dscale_w[k] = pvs_pkg::sat_wide(
			pvs_pkg::SUM_W'(coef_q[k+1]) * pvs_pkg::SUM_W'(k + 1));
	end

	always_comb begin
		dovf_w = 1'b0;
		for (int k = 0; k < pvs_pkg::NUM_COEFFS - 1; k++) begin
			dovf_w = dovf_w | dscale_w[k].ovf;
		end
	end

	// Hold the derivative coefficients
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < pvs_pkg::NUM_COEFFS - 1; k++) begin
				dcoef_q[k] <= '0;
			end
			dovf_q <= 1'b0;
		end else begin
			for (int k = 0; k < pvs_pkg::NUM_COEFFS - 1; k++) begin
				dcoef_q[k] <= dscale_w[k].val;
			end
			dovf_q <= dovf_w;
		end
	end

	// Enter a request with both accumulators at zero
	assign ctrl_w[0]      = {accept, 1'b0, param_t};
	assign prod_val_w[0]  = '0;
	assign prod_slp_w[0]  = '0;

	// Horner steps, highest coefficient first; the slope list is one shorter
	for (genvar i = 0; i < pvs_pkg::NUM_STEPS; i++) begin : g_step
		if (i == 0) begin : g_first
			assign coef_slp_w[i] = '0;
		end else begin : g_rest
			assign coef_slp_w[i] = dcoef_q[pvs_pkg::NUM_COEFFS-1-i];
		end

		pvs_step u_step (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl_in      (ctrl_w[i]),
			.prod_val_in  (prod_val_w[i]),
			.prod_slp_in  (prod_slp_w[i]),
			.coef_val     (coef_q[pvs_pkg::NUM_COEFFS-1-i]),
			.coef_slp     (coef_slp_w[i]),
			.ctrl_out     (ctrl_w[i+1]),
			.prod_val_out (prod_val_w[i+1]),
			.prod_slp_out (prod_slp_w[i+1])
		);
	end

	// Round the last products and add the constant terms
	always_comb begin
		rnd_val = pvs_pkg::round_sat(prod_val_w[pvs_pkg::NUM_STEPS]);
		rnd_slp = pvs_pkg::round_sat(prod_slp_w[pvs_pkg::NUM_STEPS]);
		fin_val = pvs_pkg::add_sat(rnd_val.val, coef_q[0]);
		fin_slp = pvs_pkg::add_sat(rnd_slp.val, dcoef_q[0]);
	end

	// Strobe the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_w[pvs_pkg::NUM_STEPS].vld;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		val_q <= fin_val.val;
		slp_q <= fin_slp.val;
		ovf_q <= ctrl_w[pvs_pkg::NUM_STEPS].ovf | rnd_val.ovf | rnd_slp.ovf
			| fin_val.ovf | fin_slp.ovf | dovf_q;
	end

	assign done       = done_q;
	assign poly_value = val_q;
	assign poly_slope = slp_q;
	assign overflow   = ovf_q;

	// Every request comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(pvs_pkg::LATENCY) done)
		else $error("request lost in pipeline");

	// No result without a request the fixed latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, pvs_pkg::LATENCY))
		else $error("result without request");

	// Result strobe follows the valid bit of the last step
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctrl_w[pvs_pkg::NUM_STEPS].vld))
		else $error("result strobe not from last step");

endmodule

`default_nettype wire
